### rtl/rse_pkg.sv
// Types, codes and microprogram of the rigid sphere Euler step sequencer.
`timescale 1ns / 1ps

package rse_pkg;

	// Microprogram geometry
	localparam int UPC_W    = 6;
	localparam int PROG_LEN = 45;
	localparam logic [UPC_W-1:0] SET_STEP = 6'd43;

	// Datapath widths
	localparam int MUL_W = 25;
	localparam int PRD_W = 2 * MUL_W;
	localparam int ACC_W = 62;
	localparam int SUM_W = 36;
	localparam int D_W   = 44;

	// Rounding biases folded into the first product of a sum
	localparam logic signed [ACC_W-1:0] BIAS16 = 62'sh0_0000_8000;
	localparam logic signed [ACC_W-1:0] BIAS33 = 62'sh1_0000_0000;

	// Saturation limits in the writeback adder width
	localparam logic signed [SUM_W-1:0] VEC_MAX  = 36'sd8388607;
	localparam logic signed [SUM_W-1:0] VEC_MIN  = -36'sd8388608;
	localparam logic signed [SUM_W-1:0] QUAT_MAX = 36'sd131071;
	localparam logic signed [SUM_W-1:0] QUAT_MIN = -36'sd131072;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_INV_MASS = 3'd0,
		CFG_INV_INER = 3'd1,
		CFG_ANG_X    = 3'd2,
		CFG_ANG_Y    = 3'd3,
		CFG_ANG_Z    = 3'd4
	} cfg_reg_t;

	// Input operation codes
	typedef enum logic {
		OP_STEP = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	// Multiplier operand A source
	typedef enum logic [3:0] {
		A_DT   = 4'd0,
		A_MOM0 = 4'd1,
		A_MOM1 = 4'd2,
		A_MOM2 = 4'd3,
		A_ANG0 = 4'd4,
		A_ANG1 = 4'd5,
		A_ANG2 = 4'd6,
		A_W0   = 4'd7,
		A_W1   = 4'd8,
		A_W2   = 4'd9
	} a_sel_t;

	// Multiplier operand B source
	typedef enum logic [3:0] {
		B_F0    = 4'd0,
		B_F1    = 4'd1,
		B_F2    = 4'd2,
		B_IMASS = 4'd3,
		B_VEL   = 4'd4,
		B_IINER = 4'd5,
		B_Q0    = 4'd6,
		B_Q1    = 4'd7,
		B_Q2    = 4'd8,
		B_Q3    = 4'd9,
		B_DLO   = 4'd10,
		B_DHI   = 4'd11
	} b_sel_t;

	// Accumulator operation on the registered product
	typedef enum logic [2:0] {
		ACC_NONE     = 3'd0,
		ACC_LOAD     = 3'd1,
		ACC_LOAD_R16 = 3'd2,
		ACC_LOAD_R33 = 3'd3,
		ACC_NEG      = 3'd4,
		ACC_ADD      = 3'd5,
		ACC_SUB      = 3'd6,
		ACC_ADD_HI   = 3'd7
	} acc_op_t;

	// Writeback destination of the accumulator
	typedef enum logic [4:0] {
		WB_NONE = 5'd0,
		WB_MOM0 = 5'd1,
		WB_MOM1 = 5'd2,
		WB_MOM2 = 5'd3,
		WB_VEL  = 5'd4,
		WB_POS0 = 5'd5,
		WB_POS1 = 5'd6,
		WB_POS2 = 5'd7,
		WB_W0   = 5'd8,
		WB_W1   = 5'd9,
		WB_W2   = 5'd10,
		WB_D    = 5'd11,
		WB_Q0   = 5'd12,
		WB_Q1   = 5'd13,
		WB_Q2   = 5'd14,
		WB_Q3   = 5'd15
	} wb_dst_t;

	// Sequencer action
	typedef enum logic [1:0] {
		SEQ_NEXT = 2'd0,
		SEQ_JSET = 2'd1,
		SEQ_END  = 2'd2
	} seq_op_t;

	// One control word
	typedef struct packed {
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		acc_op_t           acc;
		wb_dst_t           wb;
		logic              setc;
		seq_op_t           seq;
		logic [UPC_W-1:0]  target;
	} ucode_t;

	localparam ucode_t UC_NOP = '{
		a_sel:  A_DT,
		b_sel:  B_F0,
		acc:    ACC_NONE,
		wb:     WB_NONE,
		setc:   1'b0,
		seq:    SEQ_NEXT,
		target: '0
	};

	// Control store: each product is registered before the accumulator takes
	// it, and the accumulator is registered before it is written back.
	function automatic ucode_t ucode_word(input logic [UPC_W-1:0] upc);
		ucode_t uc;
		uc = UC_NOP;
		unique case (upc)
			// linear part, three axes interleaved
			6'd0: begin
				uc.a_sel = A_DT; uc.b_sel = B_F0;
				uc.seq = SEQ_JSET; uc.target = SET_STEP;
			end
			6'd1: begin
				uc.a_sel = A_DT; uc.b_sel = B_F1; uc.acc = ACC_LOAD_R16;
			end
			6'd2: begin
				uc.a_sel = A_DT; uc.b_sel = B_F2; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_MOM0;
			end
			6'd3: begin
				uc.a_sel = A_MOM0; uc.b_sel = B_IMASS; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_MOM1;
			end
			6'd4: begin
				uc.a_sel = A_MOM1; uc.b_sel = B_IMASS; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_MOM2;
			end
			6'd5: begin
				uc.a_sel = A_MOM2; uc.b_sel = B_IMASS; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_VEL;
			end
			6'd6: begin
				uc.a_sel = A_DT; uc.b_sel = B_VEL; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_VEL;
			end
			6'd7: begin
				uc.a_sel = A_DT; uc.b_sel = B_VEL; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_VEL;
			end
			6'd8: begin
				uc.a_sel = A_DT; uc.b_sel = B_VEL; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_POS0;
			end
			// angular velocity
			6'd9: begin
				uc.a_sel = A_ANG0; uc.b_sel = B_IINER; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_POS1;
			end
			6'd10: begin
				uc.a_sel = A_ANG1; uc.b_sel = B_IINER; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_POS2;
			end
			6'd11: begin
				uc.a_sel = A_ANG2; uc.b_sel = B_IINER; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_W0;
			end
			// scalar part: d0 = -(w0 qx + w1 qy + w2 qz)
			6'd12: begin
				uc.a_sel = A_W0; uc.b_sel = B_Q1; uc.acc = ACC_LOAD_R16;
				uc.wb = WB_W1;
			end
			6'd13: begin
				uc.a_sel = A_W1; uc.b_sel = B_Q2; uc.acc = ACC_NEG;
				uc.wb = WB_W2;
			end
			6'd14: begin
				uc.a_sel = A_W2; uc.b_sel = B_Q3; uc.acc = ACC_SUB;
			end
			6'd15: uc.acc = ACC_SUB;
			6'd16: uc.wb = WB_D;
			6'd17: begin
				uc.a_sel = A_DT; uc.b_sel = B_DLO;
			end
			6'd18: begin
				uc.a_sel = A_DT; uc.b_sel = B_DHI; uc.acc = ACC_LOAD_R33;
			end
			// d1 = q0 w0 + w1 qz - w2 qy
			6'd19: begin
				uc.a_sel = A_W0; uc.b_sel = B_Q0; uc.acc = ACC_ADD_HI;
			end
			6'd20: begin
				uc.a_sel = A_W1; uc.b_sel = B_Q3; uc.acc = ACC_LOAD;
				uc.wb = WB_Q0;
			end
			6'd21: begin
				uc.a_sel = A_W2; uc.b_sel = B_Q2; uc.acc = ACC_ADD;
			end
			6'd22: uc.acc = ACC_SUB;
			6'd23: uc.wb = WB_D;
			6'd24: begin
				uc.a_sel = A_DT; uc.b_sel = B_DLO;
			end
			6'd25: begin
				uc.a_sel = A_DT; uc.b_sel = B_DHI; uc.acc = ACC_LOAD_R33;
			end
			// d2 = q0 w1 + w2 qx - w0 qz
			6'd26: begin
				uc.a_sel = A_W1; uc.b_sel = B_Q0; uc.acc = ACC_ADD_HI;
			end
			6'd27: begin
				uc.a_sel = A_W2; uc.b_sel = B_Q1; uc.acc = ACC_LOAD;
				uc.wb = WB_Q1;
			end
			6'd28: begin
				uc.a_sel = A_W0; uc.b_sel = B_Q3; uc.acc = ACC_ADD;
			end
			6'd29: uc.acc = ACC_SUB;
			6'd30: uc.wb = WB_D;
			6'd31: begin
				uc.a_sel = A_DT; uc.b_sel = B_DLO;
			end
			6'd32: begin
				uc.a_sel = A_DT; uc.b_sel = B_DHI; uc.acc = ACC_LOAD_R33;
			end
			// d3 = q0 w2 + w0 qy - w1 qx
			6'd33: begin
				uc.a_sel = A_W2; uc.b_sel = B_Q0; uc.acc = ACC_ADD_HI;
			end
			6'd34: begin
				uc.a_sel = A_W0; uc.b_sel = B_Q2; uc.acc = ACC_LOAD;
				uc.wb = WB_Q2;
			end
			6'd35: begin
				uc.a_sel = A_W1; uc.b_sel = B_Q1; uc.acc = ACC_ADD;
			end
			6'd36: uc.acc = ACC_SUB;
			6'd37: uc.wb = WB_D;
			6'd38: begin
				uc.a_sel = A_DT; uc.b_sel = B_DLO;
			end
			6'd39: begin
				uc.a_sel = A_DT; uc.b_sel = B_DHI; uc.acc = ACC_LOAD_R33;
			end
			6'd40: uc.acc = ACC_ADD_HI;
			6'd41: uc.wb = WB_Q3;
			6'd42: uc.seq = SEQ_END;
			// set center path
			6'd43: uc.setc = 1'b1;
			6'd44: uc.seq = SEQ_END;
			default: uc = UC_NOP;
		endcase
		return uc;
	endfunction

endpackage

### rtl/rigid_sphere_euler_step.sv
// Top level of the rigid sphere explicit Euler step: sequencer and datapath.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready): one request per item. operation 0 runs
//   an integration step with force and dt; operation 1 overwrites the center.
// - Output channel (out_valid/out_ready): one result per request with the
//   center, the orientation quaternion and a saturation flag.
// - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
//   ready; write only while no request is in flight.
// - Sequencing: a step request runs a 43-word microprogram on one shared
//   25x25 multiplier; the next request is taken no earlier than the cycle
//   in which its result is presented. A set-center request jumps from the
//   first word to a short path. The multiplier is busy on 32 of the 43 steps.
// - The output register holds a finished result while the next request is
//   accepted and computed. If the receiver stalls, the sequencer holds on
//   its last word until the output register frees up.
// - Reset clears the state to center (0,0,0), momentum (1,0,0), identity
//   orientation and the documented register defaults.
module rigid_sphere_euler_step (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [23:0] force_x,
	input  logic signed [23:0] force_y,
	input  logic signed [23:0] force_z,
	input  logic        [15:0] dt,
	input  logic signed [23:0] new_center_x,
	input  logic signed [23:0] new_center_y,
	input  logic signed [23:0] new_center_z,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] center_x,
	output logic signed [23:0] center_y,
	output logic signed [23:0] center_z,
	output logic signed [17:0] orient_w,
	output logic signed [17:0] orient_x,
	output logic signed [17:0] orient_y,
	output logic signed [17:0] orient_z,
	output logic               saturated,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [23:0] cfg_data
);

	// Sequencer state
	logic                          busy_q;
	logic [rse_pkg::UPC_W-1:0]     pc_q;
	rse_pkg::ucode_t               ctrl;
	logic                          in_take;
	logic                          out_free;
	logic                          finish;

	// Configuration registers
	logic        [22:0] inv_mass_q;
	logic        [22:0] inv_iner_q;
	logic signed [23:0] ang_q [3];

	// Architectural state
	logic signed [23:0] pos_q [3];
	logic signed [23:0] mom_q [3];
	logic signed [17:0] quat_q [4];

	// Working registers
	logic                          op_q;
	logic        [15:0]            dt_q;
	logic signed [23:0]            frc_q [3];
	logic signed [23:0]            nc_q [3];
	logic signed [23:0]            vel_q;
	logic signed [23:0]            w_q [3];
	logic signed [rse_pkg::D_W-1:0] d_q;
	logic signed [17:0]            qn_q [4];
	logic signed [rse_pkg::PRD_W-1:0] p_q;
	logic signed [rse_pkg::ACC_W-1:0] acc_q;
	logic                          clip_q;

	// Output register
	logic                          out_valid_q;
	logic signed [23:0]            ctr_out_q [3];
	logic signed [17:0]            quat_out_q [4];
	logic                          sat_out_q;

	// Datapath nets
	logic signed [rse_pkg::MUL_W-1:0] mul_a;
	logic signed [rse_pkg::MUL_W-1:0] mul_b;
	logic signed [rse_pkg::ACC_W-1:0] p_ext;
	logic signed [rse_pkg::SUM_W-1:0] wb_base;
	logic signed [rse_pkg::SUM_W-1:0] wb_add;
	logic signed [rse_pkg::SUM_W-1:0] wb_sum;
	logic                          wb_quat;
	logic                          wb_sat;
	logic signed [23:0]            wb_v24;
	logic signed [17:0]            wb_v18;
	logic                          wb_clip;

	// Handshake terms
	assign in_ready  = !busy_q;
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Fetch the control word; idle cycles issue a no-op
	assign ctrl   = busy_q ? rse_pkg::ucode_word(pc_q) : rse_pkg::UC_NOP;
	assign finish = busy_q && (ctrl.seq == rse_pkg::SEQ_END) && out_free;

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (in_take) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else begin
			unique case (ctrl.seq)
				rse_pkg::SEQ_NEXT: pc_q <= pc_q + 1'b1;
				rse_pkg::SEQ_JSET: begin
					if (op_q == rse_pkg::OP_SET) begin
						pc_q <= ctrl.target;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				rse_pkg::SEQ_END: begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

	// Select multiplier operand A
	always_comb begin
		unique case (ctrl.a_sel)
			rse_pkg::A_DT:   mul_a = {9'd0, dt_q};
			rse_pkg::A_MOM0: mul_a = {mom_q[0][23], mom_q[0]};
			rse_pkg::A_MOM1: mul_a = {mom_q[1][23], mom_q[1]};
			rse_pkg::A_MOM2: mul_a = {mom_q[2][23], mom_q[2]};
			rse_pkg::A_ANG0: mul_a = {ang_q[0][23], ang_q[0]};
			rse_pkg::A_ANG1: mul_a = {ang_q[1][23], ang_q[1]};
			rse_pkg::A_ANG2: mul_a = {ang_q[2][23], ang_q[2]};
			rse_pkg::A_W0:   mul_a = {w_q[0][23], w_q[0]};
			rse_pkg::A_W1:   mul_a = {w_q[1][23], w_q[1]};
			rse_pkg::A_W2:   mul_a = {w_q[2][23], w_q[2]};
			default:         mul_a = '0;
		endcase
	end

	// Select multiplier operand B
	always_comb begin
		unique case (ctrl.b_sel)
			rse_pkg::B_F0:    mul_b = {frc_q[0][23], frc_q[0]};
			rse_pkg::B_F1:    mul_b = {frc_q[1][23], frc_q[1]};
			rse_pkg::B_F2:    mul_b = {frc_q[2][23], frc_q[2]};
			rse_pkg::B_IMASS: mul_b = {2'b00, inv_mass_q};
			rse_pkg::B_VEL:   mul_b = {vel_q[23], vel_q};
			rse_pkg::B_IINER: mul_b = {2'b00, inv_iner_q};
			rse_pkg::B_Q0:    mul_b = {{7{quat_q[0][17]}}, quat_q[0]};
			rse_pkg::B_Q1:    mul_b = {{7{quat_q[1][17]}}, quat_q[1]};
			rse_pkg::B_Q2:    mul_b = {{7{quat_q[2][17]}}, quat_q[2]};
			rse_pkg::B_Q3:    mul_b = {{7{quat_q[3][17]}}, quat_q[3]};
			rse_pkg::B_DLO:   mul_b = {1'b0, d_q[23:0]};
			rse_pkg::B_DHI:   mul_b = {{5{d_q[43]}}, d_q[43:24]};
			default:          mul_b = '0;
		endcase
	end

	assign p_ext = {{(rse_pkg::ACC_W - rse_pkg::PRD_W){p_q[rse_pkg::PRD_W-1]}}, p_q};

	// Pick the writeback base and the rounded accumulator slice
	always_comb begin
		wb_quat = 1'b0;
		wb_sat  = 1'b1;
		wb_base = '0;
		unique case (ctrl.wb)
			rse_pkg::WB_MOM0: wb_base = {{12{mom_q[0][23]}}, mom_q[0]};
			rse_pkg::WB_MOM1: wb_base = {{12{mom_q[1][23]}}, mom_q[1]};
			rse_pkg::WB_MOM2: wb_base = {{12{mom_q[2][23]}}, mom_q[2]};
			rse_pkg::WB_POS0: wb_base = {{12{pos_q[0][23]}}, pos_q[0]};
			rse_pkg::WB_POS1: wb_base = {{12{pos_q[1][23]}}, pos_q[1]};
			rse_pkg::WB_POS2: wb_base = {{12{pos_q[2][23]}}, pos_q[2]};
			rse_pkg::WB_VEL,
			rse_pkg::WB_W0,
			rse_pkg::WB_W1,
			rse_pkg::WB_W2:   wb_base = '0;
			rse_pkg::WB_Q0: begin
				wb_quat = 1'b1;
				wb_base = {{18{quat_q[0][17]}}, quat_q[0]};
			end
			rse_pkg::WB_Q1: begin
				wb_quat = 1'b1;
				wb_base = {{18{quat_q[1][17]}}, quat_q[1]};
			end
			rse_pkg::WB_Q2: begin
				wb_quat = 1'b1;
				wb_base = {{18{quat_q[2][17]}}, quat_q[2]};
			end
			rse_pkg::WB_Q3: begin
				wb_quat = 1'b1;
				wb_base = {{18{quat_q[3][17]}}, quat_q[3]};
			end
			default: wb_sat = 1'b0;
		endcase
	end

	assign wb_add = wb_quat ? {{7{acc_q[61]}}, acc_q[61:33]} : acc_q[51:16];
	assign wb_sum = wb_base + wb_add;

	// Saturate the writeback sum
	always_comb begin
		if (wb_sum > rse_pkg::VEC_MAX) begin
			wb_v24 = 24'sh7FFFFF;
		end else if (wb_sum < rse_pkg::VEC_MIN) begin
			wb_v24 = -24'sh800000;
		end else begin
			wb_v24 = wb_sum[23:0];
		end
		if (wb_sum > rse_pkg::QUAT_MAX) begin
			wb_v18 = 18'sh1FFFF;
		end else if (wb_sum < rse_pkg::QUAT_MIN) begin
			wb_v18 = -18'sh20000;
		end else begin
			wb_v18 = wb_sum[17:0];
		end
		if (wb_quat) begin
			wb_clip = wb_sat && ((wb_sum > rse_pkg::QUAT_MAX) || (wb_sum < rse_pkg::QUAT_MIN));
		end else begin
			wb_clip = wb_sat && ((wb_sum > rse_pkg::VEC_MAX) || (wb_sum < rse_pkg::VEC_MIN));
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= 23'd65536;
			inv_iner_q <= 23'd291271;
			ang_q[0]   <= 24'sd88474;
			ang_q[1]   <= 24'sd88474;
			ang_q[2]   <= 24'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rse_pkg::CFG_INV_MASS: inv_mass_q <= cfg_data[22:0];
				rse_pkg::CFG_INV_INER: inv_iner_q <= cfg_data[22:0];
				rse_pkg::CFG_ANG_X:    ang_q[0]   <= cfg_data;
				rse_pkg::CFG_ANG_Y:    ang_q[1]   <= cfg_data;
				rse_pkg::CFG_ANG_Z:    ang_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Update body state and the clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0]  <= '0;
			pos_q[1]  <= '0;
			pos_q[2]  <= '0;
			mom_q[0]  <= 24'sd65536;
			mom_q[1]  <= '0;
			mom_q[2]  <= '0;
			quat_q[0] <= 18'sd65536;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
			clip_q    <= 1'b0;
		end else begin
			if (in_take) begin
				clip_q <= 1'b0;
			end else if (wb_clip) begin
				clip_q <= 1'b1;
			end
			if (ctrl.setc) begin
				pos_q[0] <= nc_q[0];
				pos_q[1] <= nc_q[1];
				pos_q[2] <= nc_q[2];
			end
			unique case (ctrl.wb)
				rse_pkg::WB_MOM0: mom_q[0] <= wb_v24;
				rse_pkg::WB_MOM1: mom_q[1] <= wb_v24;
				rse_pkg::WB_MOM2: mom_q[2] <= wb_v24;
				rse_pkg::WB_POS0: pos_q[0] <= wb_v24;
				rse_pkg::WB_POS1: pos_q[1] <= wb_v24;
				rse_pkg::WB_POS2: pos_q[2] <= wb_v24;
				default: ;
			endcase
			// commit the new orientation with the result
			if (finish) begin
				quat_q[0] <= qn_q[0];
				quat_q[1] <= qn_q[1];
				quat_q[2] <= qn_q[2];
				quat_q[3] <= qn_q[3];
			end
		end
	end

	// Latch the request, multiply, accumulate and hold temporaries
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= operation;
			dt_q     <= dt;
			frc_q[0] <= force_x;
			frc_q[1] <= force_y;
			frc_q[2] <= force_z;
			nc_q[0]  <= new_center_x;
			nc_q[1]  <= new_center_y;
			nc_q[2]  <= new_center_z;
			qn_q[0]  <= quat_q[0];
			qn_q[1]  <= quat_q[1];
			qn_q[2]  <= quat_q[2];
			qn_q[3]  <= quat_q[3];
		end
		p_q <= mul_a * mul_b;
		unique case (ctrl.acc)
			rse_pkg::ACC_NONE:     ;
			rse_pkg::ACC_LOAD:     acc_q <= p_ext;
			rse_pkg::ACC_LOAD_R16: acc_q <= p_ext + rse_pkg::BIAS16;
			rse_pkg::ACC_LOAD_R33: acc_q <= p_ext + rse_pkg::BIAS33;
			rse_pkg::ACC_NEG:      acc_q <= -p_ext;
			rse_pkg::ACC_ADD:      acc_q <= acc_q + p_ext;
			rse_pkg::ACC_SUB:      acc_q <= acc_q - p_ext;
			rse_pkg::ACC_ADD_HI:   acc_q <= acc_q + {p_q[37:0], 24'd0};
			default: ;
		endcase
		unique case (ctrl.wb)
			rse_pkg::WB_VEL: vel_q   <= wb_v24;
			rse_pkg::WB_W0:  w_q[0]  <= wb_v24;
			rse_pkg::WB_W1:  w_q[1]  <= wb_v24;
			rse_pkg::WB_W2:  w_q[2]  <= wb_v24;
			rse_pkg::WB_D:   d_q     <= acc_q[rse_pkg::D_W-1:0];
			rse_pkg::WB_Q0:  qn_q[0] <= wb_v18;
			rse_pkg::WB_Q1:  qn_q[1] <= wb_v18;
			rse_pkg::WB_Q2:  qn_q[2] <= wb_v18;
			rse_pkg::WB_Q3:  qn_q[3] <= wb_v18;
			default: ;
		endcase
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (finish) begin
			ctr_out_q[0]  <= pos_q[0];
			ctr_out_q[1]  <= pos_q[1];
			ctr_out_q[2]  <= pos_q[2];
			quat_out_q[0] <= qn_q[0];
			quat_out_q[1] <= qn_q[1];
			quat_out_q[2] <= qn_q[2];
			quat_out_q[3] <= qn_q[3];
			sat_out_q     <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = ctr_out_q[0];
	assign center_y  = ctr_out_q[1];
	assign center_z  = ctr_out_q[2];
	assign orient_w  = quat_out_q[0];
	assign orient_x  = quat_out_q[1];
	assign orient_y  = quat_out_q[2];
	assign orient_z  = quat_out_q[3];
	assign saturated = sat_out_q;

	// An accepted request starts the program at its first word
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (busy_q && (pc_q == '0)))
		else $error("request did not start the microprogram");

	// The step counter stays inside the control store
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < rse_pkg::PROG_LEN))
		else $error("step counter left the control store");

	// Finishing presents a result and frees the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && !busy_q))
		else $error("finished program did not present a result");

	// A stalled receiver holds the sequencer on its last word
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (ctrl.seq == rse_pkg::SEQ_END) && !out_free) |=> (busy_q && $stable(pc_q)))
		else $error("sequencer moved while the output was stalled");

endmodule

### bench/tb_top.sv
// Testbench for the rigid sphere Euler step: directed table, random requests, state predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam logic signed [23:0] VMAX  = 24'sh7FFFFF;
	localparam logic signed [23:0] VMIN  = 24'sh800000;
	localparam logic signed [23:0] VZERO = 24'sd0;
	localparam logic signed [17:0] Q_ONE = 18'sd65536;
	localparam logic signed [17:0] QZERO = 18'sd0;
	localparam int ROWS = 20;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 250;

	// One request on the input channel
	typedef struct packed {
		rse_pkg::op_t       op;
		logic signed [23:0] fx;
		logic signed [23:0] fy;
		logic signed [23:0] fz;
		logic        [15:0] dt;
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] cz;
	} stim_t;

	// One result: center, orientation and clip flag
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] cz;
		logic signed [17:0] qw;
		logic signed [17:0] qx;
		logic signed [17:0] qy;
		logic signed [17:0] qz;
		logic               sat;
	} body_t;

	typedef struct packed {
		stim_t s;
		logic  typed;
		body_t want;
	} row_t;

	localparam body_t NO_WANT = '{VZERO, VZERO, VZERO, QZERO, QZERO, QZERO, QZERO, 1'b0};

	// Directed requests; typed rows are readable straight from reset state
	localparam row_t DIRECTED [ROWS] = '{
		'{'{rse_pkg::OP_STEP, VMAX, VMAX, VMAX, 16'h0000, VMAX, VMAX, VMAX}, 1'b1,
			'{VZERO, VZERO, VZERO, Q_ONE, QZERO, QZERO, QZERO, 1'b0}},
		'{'{rse_pkg::OP_SET, VMIN, VMIN, VMIN, 16'hFFFF, VMAX, VMAX, VMAX}, 1'b1,
			'{VMAX, VMAX, VMAX, Q_ONE, QZERO, QZERO, QZERO, 1'b0}},
		'{'{rse_pkg::OP_SET, VMAX, VMAX, VMAX, 16'hFFFF, VMIN, VMIN, VMIN}, 1'b1,
			'{VMIN, VMIN, VMIN, Q_ONE, QZERO, QZERO, QZERO, 1'b0}},
		'{'{rse_pkg::OP_STEP, VMIN, VMIN, VMIN, 16'h0000, VZERO, VMAX, VZERO}, 1'b1,
			'{VMIN, VMIN, VMIN, Q_ONE, QZERO, QZERO, QZERO, 1'b0}},
		'{'{rse_pkg::OP_SET, VZERO, VZERO, VZERO, 16'h0000, VZERO, VZERO, VZERO}, 1'b1,
			'{VZERO, VZERO, VZERO, Q_ONE, QZERO, QZERO, QZERO, 1'b0}},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'h0001, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, 24'sd1, -24'sd1, VZERO, 16'h5555, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VMAX, VMAX, VMAX, 16'hFFFF, VMIN, VMIN, VMIN},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VMIN, VMIN, VMIN, 16'hFFFF, VMAX, VMAX, VMAX},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VMIN, VMAX, 24'sh123456, 16'hAAAA, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_SET, VMAX, VMIN, VMAX, 16'hFFFF, 24'sh555555, 24'shAAAAAA, 24'sd1},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'h8000, VMAX, VMAX, VMAX},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'hFFFF, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'hFFFF, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'hFFFF, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'hFFFF, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, -24'sd65536, VZERO, VZERO, 16'h0100, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_SET, VZERO, VZERO, VZERO, 16'h0000, VMAX, VMIN, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VMAX, VMIN, VMAX, 16'h7FFF, VZERO, VZERO, VZERO},
			1'b0, NO_WANT},
		'{'{rse_pkg::OP_STEP, VZERO, VZERO, VZERO, 16'h0000, VZERO, VZERO, VZERO},
			1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic signed [23:0] force_x = '0;
	logic signed [23:0] force_y = '0;
	logic signed [23:0] force_z = '0;
	logic        [15:0] dt = '0;
	logic signed [23:0] new_center_x = '0;
	logic signed [23:0] new_center_y = '0;
	logic signed [23:0] new_center_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic signed [23:0] center_z;
	logic signed [17:0] orient_w;
	logic signed [17:0] orient_x;
	logic signed [17:0] orient_y;
	logic signed [17:0] orient_z;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// Predicted body state and register copy, at reset values
	longint sphere_pos [3] = '{0, 0, 0};
	longint sphere_mom [3] = '{65536, 0, 0};
	longint sphere_q [4] = '{65536, 0, 0, 0};
	longint inv_mass_r = 65536;
	longint inv_iner_r = 291271;
	longint ang_mom_r [3] = '{88474, 88474, 0};
	bit step_clip;

	body_t body_due [$];
	int mismatches = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold = 0;
	int rx_roll;

	rigid_sphere_euler_step dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Round half up to Q.16 (or any shift): floor of v plus half
	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Clip to a signed width and note the clip for this step
	function automatic longint clamp(longint v, int bits);
		longint lim;
		lim = longint'(1) << (bits - 1);
		if (v > lim - 1) begin
			step_clip = 1'b1;
			return lim - 1;
		end
		if (v < -lim) begin
			step_clip = 1'b1;
			return -lim;
		end
		return v;
	endfunction

	// Advance the predicted body by one request and form its result
	task automatic advance_body(input stim_t s, output body_t r);
		longint dtv, vel;
		longint f [3];
		longint w [3];
		longint d [4];
		longint q [4];
		int i;
		step_clip = 1'b0;
		if (s.op == rse_pkg::OP_SET) begin
			sphere_pos[0] = $signed(s.cx);
			sphere_pos[1] = $signed(s.cy);
			sphere_pos[2] = $signed(s.cz);
		end else begin
			dtv = longint'(s.dt);
			f[0] = $signed(s.fx);
			f[1] = $signed(s.fy);
			f[2] = $signed(s.fz);
			for (i = 0; i < 3; i++) begin
				sphere_mom[i] = clamp(sphere_mom[i] + round_q(dtv * f[i], 16), 24);
				vel = clamp(round_q(sphere_mom[i] * inv_mass_r, 16), 24);
				sphere_pos[i] = clamp(sphere_pos[i] + round_q(dtv * vel, 16), 24);
				w[i] = clamp(round_q(ang_mom_r[i] * inv_iner_r, 16), 24);
			end
			for (i = 0; i < 4; i++)
				q[i] = sphere_q[i];
			// Hamilton product (0,w)*q, kept exact
			d[0] = -(w[0] * q[1] + w[1] * q[2] + w[2] * q[3]);
			d[1] = q[0] * w[0] + (w[1] * q[3] - w[2] * q[2]);
			d[2] = q[0] * w[1] + (w[2] * q[1] - w[0] * q[3]);
			d[3] = q[0] * w[2] + (w[0] * q[2] - w[1] * q[1]);
			// half of dt times d, back to Q.16
			for (i = 0; i < 4; i++)
				sphere_q[i] = clamp(q[i] + round_q(dtv * d[i], 33), 18);
		end
		r.cx = sphere_pos[0][23:0];
		r.cy = sphere_pos[1][23:0];
		r.cz = sphere_pos[2][23:0];
		r.qw = sphere_q[0][17:0];
		r.qx = sphere_q[1][17:0];
		r.qy = sphere_q[2][17:0];
		r.qz = sphere_q[3][17:0];
		r.sat = step_clip;
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 60)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Write one register and mirror it into the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rse_pkg::CFG_INV_MASS: inv_mass_r = longint'(val[22:0]);
			rse_pkg::CFG_INV_INER: inv_iner_r = longint'(val[22:0]);
			rse_pkg::CFG_ANG_X: ang_mom_r[0] = $signed(val);
			rse_pkg::CFG_ANG_Y: ang_mom_r[1] = $signed(val);
			rse_pkg::CFG_ANG_Z: ang_mom_r[2] = $signed(val);
			default: ;
		endcase
	endtask

	// Present one request, hold it until taken, then queue its expected result
	task automatic send_stim(input stim_t s, input logic typed, input body_t want);
		body_t pred;
		in_valid <= 1'b1;
		operation <= s.op;
		force_x <= s.fx;
		force_y <= s.fy;
		force_z <= s.fz;
		dt <= s.dt;
		new_center_x <= s.cx;
		new_center_y <= s.cy;
		new_center_z <= s.cz;
		do @(posedge clk); while (!in_ready);
		advance_body(s, pred);
		body_due.push_back(typed ? want : pred);
	endtask

	// Idle the sender for a random gap, mostly short
	task automatic idle_gap();
		int roll, gap;
		roll = $urandom_range(0, 99);
		if (tx_steady || roll < 50)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (body_due.size() != 0);
	endtask

	function automatic logic [23:0] rand_vec(bit wide);
		if (wide)
			return 24'($urandom());
		return 24'($urandom_range(0, 2097151) - 1048576);
	endfunction

	// Mostly plausible steps with small dt, some full range, some center moves
	function automatic stim_t rand_stim();
		stim_t s;
		bit wide;
		wide = ($urandom_range(0, 99) < 20);
		s.op = ($urandom_range(0, 99) < 10) ? rse_pkg::OP_SET : rse_pkg::OP_STEP;
		s.fx = rand_vec(wide);
		s.fy = rand_vec(wide);
		s.fz = rand_vec(wide);
		s.dt = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4095));
		s.cx = rand_vec(wide);
		s.cy = rand_vec(wide);
		s.cz = rand_vec(wide);
		return s;
	endfunction

	// Program all registers for one phase; a few phases use the extremes
	task automatic setup_phase(input int p);
		logic [23:0] im, ii, ax, ay, az;
		im = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 262143));
		ii = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 262143));
		ax = rand_vec($urandom_range(0, 3) == 0);
		ay = rand_vec($urandom_range(0, 3) == 0);
		az = rand_vec($urandom_range(0, 3) == 0);
		case (p)
			0: begin
				im = '0;
				ii = '0;
			end
			1: begin
				im = 24'hFFFFFF;
				ii = 24'hFFFFFF;
				ax = VMAX;
				ay = VMAX;
				az = VMAX;
			end
			2: begin
				im = 24'd1;
				ii = 24'd1;
				ax = VMIN;
				ay = VMIN;
				az = VMIN;
			end
			3: begin
				im = 24'd65536;
				ii = 24'd291271;
				ax = 24'd88474;
				ay = 24'd88474;
				az = '0;
			end
			default: ;
		endcase
		write_reg(rse_pkg::CFG_INV_MASS, im);
		write_reg(3'(rse_pkg::CFG_ANG_Z) + 3'($urandom_range(1, 3)), 24'($urandom()));
		write_reg(rse_pkg::CFG_INV_INER, ii);
		write_reg(rse_pkg::CFG_ANG_X, ax);
		write_reg(rse_pkg::CFG_ANG_Y, ay);
		write_reg(rse_pkg::CFG_ANG_Z, az);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, some long, or steady acceptance
	always @(posedge clk) begin
		if (rx_hold > 0)
			rx_hold = rx_hold - 1;
		else if (rx_steady)
			out_ready <= 1'b1;
		else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 50) begin
				out_ready <= 1'b1;
				rx_hold = $urandom_range(0, 5);
			end else if (rx_roll < 90) begin
				out_ready <= 1'b0;
				rx_hold = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				rx_hold = $urandom_range(10, 60);
			end
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		body_t e;
		if (arst_n && out_valid && out_ready) begin
			if (body_due.size() == 0)
				report("result with no request outstanding");
			else begin
				e = body_due.pop_front();
				if (center_x !== e.cx)
					report($sformatf("center_x got %0d want %0d", center_x, e.cx));
				if (center_y !== e.cy)
					report($sformatf("center_y got %0d want %0d", center_y, e.cy));
				if (center_z !== e.cz)
					report($sformatf("center_z got %0d want %0d", center_z, e.cz));
				if (orient_w !== e.qw)
					report($sformatf("orient_w got %0d want %0d", orient_w, e.qw));
				if (orient_x !== e.qx)
					report($sformatf("orient_x got %0d want %0d", orient_x, e.qx));
				if (orient_y !== e.qy)
					report($sformatf("orient_y got %0d want %0d", orient_y, e.qy));
				if (orient_z !== e.qz)
					report($sformatf("orient_z got %0d want %0d", orient_z, e.qz));
				if (saturated !== e.sat)
					report($sformatf("saturated got %0b want %0b", saturated, e.sat));
			end
		end
	end

	// Main sequence: reset, directed table, then random phases
	initial begin
		int n, p, k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (n = 0; n < ROWS; n++) begin
			send_stim(DIRECTED[n].s, DIRECTED[n].typed, DIRECTED[n].want);
			if (n != ROWS - 1)
				idle_gap();
		end
		drain();
		for (p = 0; p < PHASES; p++) begin
			setup_phase(p);
			tx_steady = (p % 3 == 1);
			rx_steady = (p % 3 == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				send_stim(rand_stim(), 1'b0, NO_WANT);
				// hold off mid phase until the pipe is empty
				if (p == 4 && k == PHASE_ITEMS / 2)
					drain();
				else if (k != PHASE_ITEMS - 1)
					idle_gap();
			end
			drain();
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && body_due.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// Watchdog
	initial begin
		#6000000;
		$display("tb_top failed");
		$finish;
	end

endmodule
